// ===== sv/pwl_pkg.sv =====
// Package for the piecewise-linear table interpolator.
// Holds request, mode and status codes, arithmetic widths and the queue entry type; no dependencies.
package pwl_pkg;
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic MODE_LIN  = 1'b0;
  localparam logic MODE_INV2 = 1'b1;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam int NUM_W = 192;
  localparam int DEN_W = 128;
  localparam int Q_W   = 35;
  localparam int MA_W  = 128;
  localparam int MB_W  = 64;

  typedef struct packed {
    logic               req_type;
    logic [9:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
    logic               interp_mode;
  } item_t;
endpackage

// ===== sv/piecewise_linear_table_interp_top.sv =====
// Top level of the piecewise-linear table interpolator.
// Depends on pwl_pkg, pwl_queue and pwl_back.

// Input transactions enter a two-entry queue; the back end writes a load
// transaction into the breakpoint memories as it takes it. A query scans
// the breakpoints in use one at a time (registered memory read, then a
// compare) and stops at the first slot whose x is not below the query. Below
// the first point, with one point in use, or above the last point it returns
// a stored ordinate at once. Otherwise the operands are built by a multiplier
// that forms one 32 by 32 partial product per cycle (one product in linear
// mode, three in inverse-square mode), and a bit-serial divider forms the
// quotient. Results leave through an output register; a query waits in the
// queue while a result is still held there.
module piecewise_linear_table_interp_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [5:0]         in_point_index,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_query_x,
  input  logic               in_interp_mode,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_point_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_result_status
);
  import pwl_pkg::*;
  logic [6:0] count_r;
  item_t wr_item, rd_item;
  logic wr_ready, rd_valid, rd_take;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= 7'd1;
    else if (cfg_valid) count_r <= cfg_point_count;
  end

  always_comb begin
    wr_item.req_type    = in_req_type;
    wr_item.point_index = 10'(in_point_index);
    wr_item.point_x     = in_point_x;
    wr_item.point_y     = in_point_y;
    wr_item.query_x     = in_query_x;
    wr_item.interp_mode = in_interp_mode;
  end
  assign in_stall = !wr_ready;

  pwl_queue u_q (.clk(clk), .rst_n(rst_n), .wr_valid(in_valid), .wr_ready(wr_ready),
    .wr_data(wr_item), .rd_valid(rd_valid), .rd_take(rd_take), .rd_data(rd_item));

  pwl_back #(.MAX_POINTS(MAX_POINTS)) u_back (.clk(clk), .rst_n(rst_n),
    .point_count(count_r), .q_valid(rd_valid), .q_take(rd_take), .q_data(rd_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_result_status(out_result_status));
endmodule

// ===== sv/pwl_queue.sv =====
// Two-entry queue between the front and the back of the interpolator.
// Depends on pwl_pkg for the item type.
module pwl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  pwl_pkg::item_t wr_data,
  output logic          rd_valid,
  input  logic          rd_take,
  output pwl_pkg::item_t rd_data
);
  import pwl_pkg::*;
  item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_take && rd_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_take && rd_valid);
    end
  end
endmodule

// ===== sv/pwl_divider.sv =====
// Multi-cycle arithmetic for the back end: a restoring divider, one quotient bit per
// cycle with the quotient capped like the table math, and a digit-serial multiplier.
// Depends on pwl_pkg for widths.
module pwl_divider (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [pwl_pkg::NUM_W-1:0] num,
  input  logic [pwl_pkg::DEN_W-1:0] den,
  output logic                    done,
  output logic [pwl_pkg::Q_W-1:0]   quo
);
  import pwl_pkg::*;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r;
  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] q_r;
  logic [7:0]       cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  always_comb begin
    sh   = {rem_r[DEN_W-1:0], n_r[NUM_W-1]};
    diff = sh - {1'b0, d_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_r <= num; d_r <= den; rem_r <= '0; q_r <= '0;
        cnt_r <= 8'(NUM_W); busy_r <= 1'b1;
      end else if (busy_r) begin
        n_r <= n_r << 1;
        if (!diff[DEN_W]) begin
          rem_r <= diff; q_r <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= sh; q_r <= {q_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          busy_r <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
  assign quo = (q_r[NUM_W-1:Q_W-1] != '0) ? {1'b1, {(Q_W-1){1'b0}}} : q_r[Q_W-1:0];
endmodule

// Multiplies a 128-bit operand by a 64-bit operand with one 32 by 32 partial
// product per cycle.
module pwl_mult (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [pwl_pkg::MA_W-1:0]  a,
  input  logic [pwl_pkg::MB_W-1:0]  b,
  output logic                    done,
  output logic [pwl_pkg::NUM_W-1:0] prod
);
  import pwl_pkg::*;
  logic [MA_W-1:0]  a_r;
  logic [MB_W-1:0]  b_r;
  logic [NUM_W-1:0] acc_r;
  logic [1:0]       ai_r;
  logic             bi_r;
  logic             busy_r;
  logic [31:0]      ad, bd;
  logic [63:0]      pp;
  logic [NUM_W-1:0] pp_sh;
  always_comb begin
    ad    = a_r[{ai_r, 5'd0} +: 32];
    bd    = b_r[{bi_r, 5'd0} +: 32];
    pp    = 64'(ad) * 64'(bd);
    pp_sh = NUM_W'(pp) << {3'(ai_r) + 3'(bi_r), 5'd0};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r <= a; b_r <= b; acc_r <= '0; ai_r <= 2'd0; bi_r <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + pp_sh;
        bi_r <= ~bi_r;
        if (bi_r) ai_r <= ai_r + 2'd1;
        if (bi_r && ai_r == 2'd3) begin
          busy_r <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
  assign prod = acc_r;
endmodule

// ===== sv/pwl_back.sv =====
// Back end: table storage, breakpoint scan, operand build and result output.
// Depends on pwl_pkg, pwl_divider and pwl_mult.
module pwl_back #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          point_count,
  input  logic                q_valid,
  output logic                q_take,
  input  pwl_pkg::item_t      q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_result_value,
  output logic [1:0]          out_result_status
);
  import pwl_pkg::*;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_M1, S_M2, S_MN, S_MD, S_CHK, S_MDY, S_DIV, S_OUT
  } state_t;
  state_t st_r;

  logic [31:0] xmem_r [MAX_POINTS];
  logic [31:0] ymem_r [MAX_POINTS];
  logic [31:0] xrd_r, yrd_r;
  logic [AW-1:0] raddr;
  logic [CW-1:0] cnt_r, i_r;
  item_t it_r;
  logic signed [31:0] x0_r, x1_r, y0_r, prevx_r, prevy_r;
  logic signed [32:0] dy_r;
  logic [63:0] a_r, p_r, b_r, e1m_r, e2m_r;
  logic neg_r;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r;
  logic [MA_W-1:0] ma_r;
  logic [MB_W-1:0] mb_r;
  logic mul_start_r, mul_done;
  logic [NUM_W-1:0] mul_prod;
  logic div_start_r, div_done;
  logic [Q_W-1:0] quo;
  logic signed [31:0] res_v_r;
  logic [1:0] res_s_r;
  logic [CW-1:0] cnt_eff;
  logic signed [63:0] e1s, e2s;
  logic signed [36:0] sum;
  logic out_fire;

  always_comb begin
    if (point_count == 7'd0) cnt_eff = CW'(1);
    else if (32'(point_count) > MAX_POINTS) cnt_eff = CW'(MAX_POINTS);
    else cnt_eff = CW'(point_count);
  end

  function automatic logic [31:0] absv(input logic signed [32:0] v);
    logic signed [32:0] t;
    begin
      t = v < 0 ? -v : v;
      return t[31:0];
    end
  endfunction

  assign q_take = (st_r == S_IDLE) && q_valid &&
                  (q_data.req_type == REQ_LOAD || !out_valid);
  assign raddr  = i_r[AW-1:0];
  assign out_fire = (st_r == S_OUT) && (!out_valid || !out_stall);

  pwl_mult u_mul (.clk(clk), .rst_n(rst_n), .start(mul_start_r), .a(ma_r), .b(mb_r),
    .done(mul_done), .prod(mul_prod));

  pwl_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start_r), .num(n_r),
    .den(d_r), .done(div_done), .quo(quo));

  always_ff @(posedge clk) begin
    if (q_take && q_data.req_type == REQ_LOAD &&
        32'(q_data.point_index) < MAX_POINTS) begin
      xmem_r[q_data.point_index[AW-1:0]] <= q_data.point_x;
      ymem_r[q_data.point_index[AW-1:0]] <= q_data.point_y;
    end
    xrd_r <= xmem_r[raddr];
    yrd_r <= ymem_r[raddr];
  end

  always_comb begin
    e1s = $signed(a_r) - $signed(p_r);
    e2s = $signed(a_r) - $signed(b_r);
    sum = neg_r ? 37'(y0_r) - 37'(quo) : 37'(y0_r) + 37'(quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0; div_start_r <= 1'b0; mul_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      if (out_fire) begin
        out_valid <= 1'b1;
        out_result_value  <= res_v_r;
        out_result_status <= res_s_r;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (q_take && q_data.req_type == REQ_QUERY) begin
            it_r <= q_data; cnt_r <= cnt_eff; i_r <= '0; st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_CMP;
        S_CMP: begin
          // Scan for the first slot whose x is not below the query.
          if (cnt_r == CW'(1) ||
              (i_r == '0 && !(it_r.query_x > $signed(xrd_r)))) begin
            res_v_r <= $signed(yrd_r); res_s_r <= ST_OK; st_r <= S_OUT;
          end else if (!(it_r.query_x > $signed(xrd_r))) begin
            x1_r <= $signed(xrd_r); dy_r <= 33'($signed(yrd_r)) - 33'(prevy_r);
            x0_r <= prevx_r; y0_r <= prevy_r;
            st_r <= S_M1;
          end else if (i_r + CW'(1) == cnt_r) begin
            res_v_r <= $signed(yrd_r); res_s_r <= ST_OK; st_r <= S_OUT;
          end else begin
            prevx_r <= $signed(xrd_r); prevy_r <= $signed(yrd_r);
            i_r <= i_r + CW'(1); st_r <= S_RD;
          end
        end
        S_M1: begin
          if (it_r.interp_mode == MODE_LIN) begin
            n_r <= NUM_W'(absv(33'(it_r.query_x) - 33'(x0_r)));
            d_r <= DEN_W'(absv(33'(x1_r) - 33'(x0_r)));
            neg_r <= (dy_r < 0) ^ (33'(it_r.query_x) - 33'(x0_r) < 0)
                     ^ (33'(x1_r) - 33'(x0_r) < 0);
            st_r <= S_CHK;
          end else begin
            neg_r <= dy_r < 0;
            a_r <= 64'(absv(33'(x0_r))) * 64'(absv(33'(x0_r)));
            p_r <= 64'(absv(33'(it_r.query_x))) * 64'(absv(33'(it_r.query_x)));
            b_r <= 64'(absv(33'(x1_r))) * 64'(absv(33'(x1_r)));
            st_r <= S_M2;
          end
        end
        S_M2: begin
          e1m_r <= e1s < 0 ? 64'(-e1s) : 64'(e1s);
          e2m_r <= e2s < 0 ? 64'(-e2s) : 64'(e2s);
          neg_r <= neg_r ^ (e1s < 0) ^ (e2s < 0);
          ma_r <= MA_W'(e1s < 0 ? 64'(-e1s) : 64'(e1s));
          mb_r <= b_r;
          mul_start_r <= 1'b1;
          st_r <= S_MN;
        end
        S_MN: begin
          // Numerator product done; the divisor product follows.
          if (mul_done) begin
            n_r <= mul_prod;
            ma_r <= MA_W'(e2m_r);
            mb_r <= p_r;
            mul_start_r <= 1'b1;
            st_r <= S_MD;
          end
        end
        S_MD: begin
          if (mul_done) begin
            d_r <= mul_prod[DEN_W-1:0];
            st_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (d_r == '0) begin
            if (it_r.interp_mode == MODE_LIN) begin
              res_v_r <= y0_r; res_s_r <= ST_OK;
            end else begin
              res_v_r <= '0; res_s_r <= ST_DIV0;
            end
            st_r <= S_OUT;
          end else begin
            ma_r <= n_r[MA_W-1:0];
            mb_r <= MB_W'(absv(dy_r));
            mul_start_r <= 1'b1;
            st_r <= S_MDY;
          end
        end
        S_MDY: begin
          if (mul_done) begin
            n_r <= mul_prod;
            div_start_r <= 1'b1;
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (sum > 37'sh7FFFFFFF) begin
              res_v_r <= 32'h7FFFFFFF; res_s_r <= ST_SAT;
            end else if (sum < -37'sh80000000) begin
              res_v_r <= 32'h80000000; res_s_r <= ST_SAT;
            end else begin
              res_v_r <= sum[31:0]; res_s_r <= ST_OK;
            end
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for piecewise_linear_table_interp_top.
// Depends on pwl_pkg and the top level; predicts every query result on its own.
`timescale 1ns / 1ps

module tb;
  import pwl_pkg::*;

  localparam int NSLOT = 64;
  // Leave headroom for a query at full table size.
  localparam int DRAIN_CYCLES = 450;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = REQ_LOAD;
  logic [5:0]         in_point_index = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_query_x = '0;
  logic               in_interp_mode = MODE_LIN;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cfg_point_count = 7'd1;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic [1:0]         out_result_status;

  piecewise_linear_table_interp_top uut (.*);

  // The clock toggles every half period of 10 ns.
  always #5 clk = ~clk;

  // Predictor state: its own copy of the breakpoint table and the count.
  logic signed [31:0] model_x[NSLOT];
  logic signed [31:0] model_y[NSLOT];
  logic [6:0]         model_count;

  item_t   pending_items[$];
  answer_t expected_answers[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      no_gaps = 0;
  int      in_gap = 0;
  int      out_wait = 0;
  logic    in_taken = 1'b0;
  logic    out_taken = 1'b0;
  logic    cfg_taken = 1'b0;

  // Table the stimulus generator keeps in mind to aim queries at.
  logic signed [31:0] plan_x[NSLOT];
  int plan_count;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Computes what a query transaction must return, following the scan and
  // the exact wide arithmetic of the interpolation.
  function automatic answer_t interpolate(input item_t it);
    answer_t ans;
    int cnt, i;
    longint x, x0, x1, y0, dy, val, e1, e2;
    logic [63:0] a, p, b;
    logic [191:0] num, den, quo;
    bit neg;
    cnt = model_count;
    if (cnt == 0) cnt = 1;
    if (cnt > NSLOT) cnt = NSLOT;
    x = it.query_x;
    i = 0;
    if (cnt > 1)
      while (i < cnt && x > longint'(model_x[i])) i++;
    ans.status = ST_OK;
    if (cnt == 1 || i == 0) begin
      val = model_y[0];
    end else if (i == cnt) begin
      val = model_y[cnt-1];
    end else begin
      x0 = model_x[i-1];
      x1 = model_x[i];
      y0 = model_y[i-1];
      dy = longint'(model_y[i]) - y0;
      neg = dy < 0;
      if (it.interp_mode == MODE_LIN) begin
        num = 192'(magnitude(x - x0));
        den = 192'(magnitude(x1 - x0));
        neg = neg ^ ((x - x0) < 0) ^ ((x1 - x0) < 0);
      end else begin
        a = magnitude(x0) * magnitude(x0);
        p = magnitude(x) * magnitude(x);
        b = magnitude(x1) * magnitude(x1);
        e1 = longint'(a) - longint'(p);
        e2 = longint'(a) - longint'(b);
        num = 192'(magnitude(e1)) * 192'(b);
        den = 192'(magnitude(e2)) * 192'(p);
        neg = neg ^ (e1 < 0) ^ (e2 < 0);
      end
      if (den == 0) begin
        if (it.interp_mode == MODE_LIN) begin
          val = y0;
        end else begin
          val = 0;
          ans.status = ST_DIV0;
        end
      end else begin
        num = num * 192'(magnitude(dy));
        quo = num / den;
        // Anything at or past 2^34 saturates anyway, so cap it there.
        if (quo >= (192'(1) << 34)) quo = 192'(1) << 34;
        val = neg ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
        if (val > 64'sh7FFFFFFF) begin
          val = 64'sh7FFFFFFF;
          ans.status = ST_SAT;
        end else if (val < -64'sh80000000) begin
          val = -64'sh80000000;
          ans.status = ST_SAT;
        end
      end
    end
    ans.value = val[31:0];
    return ans;
  endfunction

  // Every rising edge: count cycles, record handshakes, update the predictor
  // on accepted transactions and check accepted results.
  always @(posedge clk) begin
    answer_t got, want;
    item_t it;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (!rst_n) begin
      model_count <= 7'd1;
    end else begin
      if (cfg_valid && cfg_ready) model_count <= cfg_point_count;
      if (in_valid && !in_stall) begin
        it.req_type    = in_req_type;
        it.point_index = 10'(in_point_index);
        it.point_x     = in_point_x;
        it.point_y     = in_point_y;
        it.query_x     = in_query_x;
        it.interp_mode = in_interp_mode;
        if (it.req_type == REQ_LOAD) begin
          model_x[in_point_index] = in_point_x;
          model_y[in_point_index] = in_point_y;
        end else begin
          expected_answers.insert(expected_answers.size(), interpolate(it));
        end
      end
      if (out_valid && !out_stall) begin
        got.value  = out_result_value;
        got.status = out_result_status;
        if (expected_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h status %0d",
                                    got.value, got.status));
        end else begin
          want = expected_answers.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("value %h, expected %h", got.value, want.value));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      got.status, want.status));
        end
      end
    end
  end

  // Input driver: holds a stalled transaction, otherwise waits out its drawn
  // gap and presents the next pending item at the falling edge.
  always @(negedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_req_type    <= it.req_type;
        in_point_index <= it.point_index[5:0];
        in_point_x     <= it.point_x;
        in_point_y     <= it.point_y;
        in_query_x     <= it.query_x;
        in_interp_mode <= it.interp_mode;
        in_valid <= 1'b1;
        in_gap <= no_gaps ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: after every accepted result, stall for a drawn number of cycles.
  always @(negedge clk) begin
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_taken) begin
      w = no_gaps ? 0 : $urandom_range(0, 12);
      out_wait <= (w > 0) ? w - 1 : 0;
      out_stall <= (w > 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_load(input int slot, input logic [31:0] px, input logic [31:0] py);
    item_t it;
    it = '0;
    it.req_type = REQ_LOAD;
    it.point_index = 10'(slot);
    it.point_x = px;
    it.point_y = py;
    it.query_x = $urandom;
    it.interp_mode = $urandom_range(0, 1);
    pending_items.insert(pending_items.size(), it);
    plan_x[slot] = px;
  endtask

  task automatic add_query(input logic [31:0] qx, input logic mode);
    item_t it;
    it = '0;
    it.req_type = REQ_QUERY;
    it.point_index = $urandom_range(0, NSLOT - 1);
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.query_x = qx;
    it.interp_mode = mode;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Waits until every transaction is out and the block has drained.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [6:0] cnt);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_point_count <= cnt;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
    plan_count = (cnt == 0) ? 1 : (cnt > NSLOT) ? NSLOT : cnt;
  endtask

  // Loads all slots so that no count can reach an unwritten entry.
  // Table flavors: wide sorted, narrow sorted with repeats, mirrored around
  // zero (equal squares), and unsorted.
  task automatic load_table(input int flavor);
    logic signed [31:0] xs[NSLOT];
    logic signed [31:0] tmp;
    logic [31:0] yv;
    int span;
    span = $urandom_range(4, 24);
    for (int k = 0; k < NSLOT; k++) begin
      case (flavor)
        0: xs[k] = $urandom;
        1: xs[k] = $signed($urandom_range(0, 2 ** span)) - 2 ** (span - 1);
        2: xs[k] = (k < NSLOT / 2) ? -((NSLOT / 2 - k) <<< span) : ((k - NSLOT / 2 + 1) <<< span);
        default: xs[k] = $urandom;
      endcase
    end
    if (flavor == 0) begin
      xs[0] = 32'sh80000000;
      xs[NSLOT-1] = 32'sh7FFFFFFF;
    end
    if (flavor != 3)
      for (int m = 0; m < NSLOT; m++)
        for (int k = 0; k < NSLOT - 1 - m; k++)
          if (xs[k] > xs[k+1]) begin
            tmp = xs[k];
            xs[k] = xs[k+1];
            xs[k+1] = tmp;
          end
    for (int k = 0; k < NSLOT; k++) begin
      yv = ($urandom_range(0, 2) == 0) ? $urandom : 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
      add_load(k, xs[k], yv);
    end
  endtask

  // Queries aimed mostly at and between the breakpoints in use.
  task automatic add_random_queries(input int num);
    int j;
    longint lo, hi;
    logic [31:0] qx;
    for (int k = 0; k < num; k++) begin
      j = $urandom_range(0, plan_count - 1);
      lo = plan_x[j];
      hi = (j + 1 < plan_count) ? longint'(plan_x[j+1]) : lo + 1000;
      if (hi < lo) hi = lo;
      case ($urandom_range(0, 9))
        0: qx = plan_x[j];
        1: qx = 0;
        2: qx = ($urandom_range(0, 1) == 1) ? 32'h7FFFFFFF : 32'h80000000;
        3: qx = $urandom;
        4: qx = 32'(lo - $urandom_range(1, 100));
        default: qx = 32'(lo + longint'($urandom) % (hi - lo + 1));
      endcase
      add_query(qx, $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    plan_count = 1;

    // One point in use after reset: every query returns its ordinate.
    add_load(0, 32'h80000000, 32'h7FFFFFFF);
    add_query(32'h80000000, MODE_LIN);
    add_query(32'h7FFFFFFF, MODE_INV2);
    wait_idle();

    // Two points mirrored around zero: the inverse-square divisor vanishes,
    // as it does for a query at zero; linear mode still interpolates.
    write_count(7'd2);
    add_load(0, -32'sd327680, 32'h00010000);
    add_load(1, 32'sd327680, 32'hFFFF0000);
    add_query(32'h00000000, MODE_INV2);
    add_query(32'h00010000, MODE_INV2);
    add_query(32'h00010000, MODE_LIN);
    add_query(-32'sd400000, MODE_LIN);
    add_query(32'sd400000, MODE_LIN);
    add_query(32'sd327680, MODE_LIN);
    wait_idle();

    // Steep inverse-square segment that drives the sum past the top, and a
    // falling segment that drives it past the bottom.
    add_load(0, -32'sd100, 32'h00000000);
    add_load(1, 32'sd2, 32'h7FFFFFFF);
    add_query(32'sd1, MODE_INV2);
    add_query(-32'sd99, MODE_LIN);
    add_load(0, -32'sd100, 32'h00000000);
    add_load(1, 32'sd2, 32'h80000000);
    add_query(32'sd1, MODE_INV2);
    add_query(32'sd2, MODE_INV2);
    wait_idle();

    // Random phases: the full table, the values that act as one and as the
    // full table, a single point, and one count drawn in between.
    for (int ph = 0; ph < 5; ph++) begin
      logic [6:0] cnt;
      case (ph)
        0: cnt = 7'd64;
        1: cnt = 7'd0;
        2: cnt = 7'd127;
        3: cnt = 7'd1;
        default: cnt = $urandom_range(2, 63);
      endcase
      no_gaps = (ph % 4 == 3);
      write_count(cnt);
      load_table(ph % 4);
      add_random_queries(55);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
